>>> rtl/text_console_cursor_engine_assert.svh
// Assertion macros for the text console cursor engine.
// Included by the top level; expects aclk and aresetn in scope.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH

// Property that must hold at every clock edge outside reset
`define TCCE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Condition that must never be true outside reset
`define TCCE_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

>>> rtl/tcce_pkg.sv
// Shared types, constants and color functions for the text console cursor engine.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package tcce_pkg;

    // Sizing
    localparam int SCROLL_SPAN_DEF = 256;
    localparam int MAX_COLUMNS     = 64;
    localparam int MAX_ROWS        = 32;
    localparam int COL_W           = 8;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_LEFT   = 3'd2,
        REG_TOP    = 3'd3,
        REG_TAB    = 3'd4,
        REG_CELLH  = 3'd5,
        REG_FIRST  = 3'd6,
        REG_COUNT  = 3'd7
    } tcce_reg_t;

    // Register reset values
    localparam logic [6:0] RST_WIDTH  = 7'd32;
    localparam logic [5:0] RST_HEIGHT = 6'd24;
    localparam logic [5:0] RST_LEFT   = 6'd0;
    localparam logic [4:0] RST_TOP    = 5'd0;
    localparam logic [4:0] RST_TAB    = 5'd4;
    localparam logic [4:0] RST_CELLH  = 5'd8;
    localparam logic [7:0] RST_FIRST  = 8'd0;
    localparam logic [8:0] RST_COUNT  = 9'd256;

    // Character codes with special handling
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // Result kinds
    localparam logic KIND_DRAW   = 1'b0;
    localparam logic KIND_SCROLL = 1'b1;

    localparam logic [15:0] OPAQUE      = 16'h8000;
    localparam logic [15:0] CLEAR_COLOR = 16'h8000;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_TAB,
        ST_EXEC,
        ST_EMIT
    } tcce_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic wrap;
        logic rem_start;
        logic tab_apply;
        logic exec;
        logic pop;
    } tcce_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_nul;
        logic is_tab;
        logic rem_done;
        logic has_result;
        logic last;
    } tcce_sts_t;

    // First 16 entries of the palette
    function automatic logic [14:0] ansi16(input logic [3:0] idx);
        logic [14:0] c;
        case (idx)
            4'd0:    c = 15'h0000;
            4'd1:    c = 15'h000F;
            4'd2:    c = 15'h01E0;
            4'd3:    c = 15'h01EF;
            4'd4:    c = 15'h3C00;
            4'd5:    c = 15'h3C0F;
            4'd6:    c = 15'h3DE0;
            4'd7:    c = 15'h6318;
            4'd8:    c = 15'h3DEF;
            4'd9:    c = 15'h001F;
            4'd10:   c = 15'h03E0;
            4'd11:   c = 15'h03FF;
            4'd12:   c = 15'h7C00;
            4'd13:   c = 15'h7C1F;
            4'd14:   c = 15'h7FE0;
            default: c = 15'h7FFF;
        endcase
        return c;
    endfunction

    // Color cube level 0..5 to a 5-bit channel
    function automatic logic [4:0] cube_level(input logic [2:0] v);
        logic [8:0] t;
        t = 9'(v) * 9'd40 + 9'd55;
        return (v == 3'd0) ? 5'd0 : t[7:3];
    endfunction

    // xterm 256 palette entry as RGB15 (red lowest)
    function automatic logic [14:0] palette_rgb(input logic [7:0] idx);
        logic [7:0] k;
        logic [2:0] r;
        logic [2:0] g;
        logic [5:0] r36;
        logic [5:0] b6;
        logic [7:0] gt;
        logic [14:0] c;
        k   = idx - 8'd16;
        // split k into base-6 digits with threshold compares
        if (k >= 8'd180)      r = 3'd5;
        else if (k >= 8'd144) r = 3'd4;
        else if (k >= 8'd108) r = 3'd3;
        else if (k >= 8'd72)  r = 3'd2;
        else if (k >= 8'd36)  r = 3'd1;
        else                  r = 3'd0;
        r36 = 6'(k - 8'(r) * 8'd36);
        if (r36 >= 6'd30)      g = 3'd5;
        else if (r36 >= 6'd24) g = 3'd4;
        else if (r36 >= 6'd18) g = 3'd3;
        else if (r36 >= 6'd12) g = 3'd2;
        else if (r36 >= 6'd6)  g = 3'd1;
        else                   g = 3'd0;
        b6  = r36 - 6'(g) * 6'd6;
        gt  = (idx - 8'd232) * 8'd10 + 8'd8;
        if (idx < 8'd16) begin
            c = ansi16(idx[3:0]);
        end else if (idx < 8'd232) begin
            c = {cube_level(b6[2:0]), cube_level(g), cube_level(r)};
        end else begin
            c = {gt[7:3], gt[7:3], gt[7:3]};
        end
        return c;
    endfunction

    // Palette or truncated 24-bit color, with the opaque bit set
    function automatic logic [15:0] pick_color(input logic is_rgb, input logic [7:0] index,
                                               input logic [23:0] rgb);
        logic [15:0] c;
        if (is_rgb) begin
            c = {1'b1, rgb[7:3], rgb[15:11], rgb[23:19]};
        end else begin
            c = {1'b1, palette_rgb(index)};
        end
        return c;
    endfunction

endpackage

>>> rtl/tcce_rem.sv
// Bit-serial remainder unit: one dividend bit per cycle.
// Uses tcce_pkg for the cursor column width.
`timescale 1ns / 1ps

module tcce_rem (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [tcce_pkg::COL_W-1:0] dividend,
    input  logic [4:0]                divisor,
    output logic [4:0]                rem,
    output logic                      done
);

    localparam int CNT_W = $clog2(tcce_pkg::COL_W);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [tcce_pkg::COL_W-1:0] dvd_reg, dvd_next;
    logic [4:0]                 dvs_reg, dvs_next;
    logic [4:0]                 rem_reg, rem_next;
    logic [5:0]                 trial;
    logic [5:0]                 diff;

    // Restoring step: shift in next bit, subtract if it fits
    assign trial = {rem_reg, dvd_reg[tcce_pkg::COL_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next = (trial >= {1'b0, dvs_reg}) ? diff[4:0] : trial[4:0];
            dvd_next = {dvd_reg[tcce_pkg::COL_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(tcce_pkg::COL_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

>>> rtl/tcce_ctrl.sv
// Controller state machine for the text console cursor engine.
// Uses tcce_pkg for state, command and status types.
`timescale 1ns / 1ps

module tcce_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output tcce_pkg::tcce_cmd_t cmd,
    input  tcce_pkg::tcce_sts_t sts
);

    tcce_pkg::tcce_state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tcce_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            tcce_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = tcce_pkg::ST_WRAP;
                end
            end
            tcce_pkg::ST_WRAP: begin
                if (sts.is_nul) begin
                    state_next = tcce_pkg::ST_IDLE;
                end else begin
                    cmd.wrap = 1'b1;
                    if (sts.is_tab) begin
                        cmd.rem_start = 1'b1;
                        state_next    = tcce_pkg::ST_TAB;
                    end else begin
                        state_next = tcce_pkg::ST_EXEC;
                    end
                end
            end
            tcce_pkg::ST_TAB: begin
                if (sts.rem_done) begin
                    cmd.tab_apply = 1'b1;
                    state_next    = tcce_pkg::ST_EMIT;
                end
            end
            tcce_pkg::ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = tcce_pkg::ST_EMIT;
            end
            tcce_pkg::ST_EMIT: begin
                if (!sts.has_result) begin
                    state_next = tcce_pkg::ST_IDLE;
                end else begin
                    m_tvalid = 1'b1;
                    if (m_tready) begin
                        cmd.pop = 1'b1;
                        if (sts.last) begin
                            state_next = tcce_pkg::ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = tcce_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/tcce_dp.sv
// Datapath: configuration registers, cursor and scroll state, result slots.
// Uses tcce_pkg and the tcce_rem remainder unit for tab stops.
`timescale 1ns / 1ps

module tcce_dp #(
    parameter int SCROLL_SPAN = tcce_pkg::SCROLL_SPAN_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_addr,
    input  logic [8:0]          cfg_wr_data,
    // input fields
    input  logic [7:0]          char_code,
    input  logic                fg_is_rgb,
    input  logic [7:0]          fg_index,
    input  logic [23:0]         fg_rgb,
    input  logic                bg_is_rgb,
    input  logic [7:0]          bg_index,
    input  logic [23:0]         bg_rgb,
    // control
    input  tcce_pkg::tcce_cmd_t cmd,
    output tcce_pkg::tcce_sts_t sts,
    // result fields
    output logic                kind,
    output logic [7:0]          glyph,
    output logic [6:0]          column,
    output logic [5:0]          row,
    output logic [15:0]         fg_color,
    output logic [15:0]         bg_color,
    output logic [7:0]          scroll_offset
);

    localparam int SCROLL_W = $clog2(SCROLL_SPAN);
    localparam int SW1      = SCROLL_W + 1;

    // Configuration registers
    logic [6:0] width_reg;
    logic [5:0] height_reg;
    logic [5:0] left_reg;
    logic [4:0] top_reg;
    logic [4:0] tab_reg;
    logic [4:0] cellh_reg;
    logic [7:0] first_reg;
    logic [8:0] count_reg;

    // Cursor and scroll state
    logic [7:0]          col_reg, col_next;
    logic [5:0]          row_reg, row_next;
    logic [SCROLL_W-1:0] scroll_reg, scroll_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic                rd_reg, rd_next;

    // Latched item
    logic [7:0]  char_reg;
    logic [15:0] fg_reg;
    logic [15:0] bg_reg;

    // Two result slots
    logic        slot_kind_reg  [2];
    logic [7:0]  slot_glyph_reg [2];
    logic [6:0]  slot_col_reg   [2];
    logic [5:0]  slot_row_reg   [2];
    logic [15:0] slot_fg_reg    [2];
    logic [15:0] slot_bg_reg    [2];

    logic        push;
    logic        push_kind;
    logic [7:0]  push_glyph;
    logic [6:0]  push_col;
    logic [5:0]  push_row;
    logic [15:0] push_fg;
    logic [15:0] push_bg;

    logic [7:0]  w_eff;
    logic [6:0]  h_eff;
    logic [4:0]  tab_eff;
    logic        col_wrap;
    logic [5:0]  nr_row1;
    logic        nr_scroll;
    logic [5:0]  nr_row;
    logic [6:0]  scroll_row_sum;
    logic [SW1-1:0] scroll_sum;
    logic [SCROLL_W-1:0] scroll_adv;
    logic [9:0]  glyph_end;
    logic        glyph_out;
    logic [7:0]  glyph_sel;
    logic [7:0]  draw_col_sum;
    logic [5:0]  draw_row_sum;
    logic [7:0]  rem_dividend;
    logic [4:0]  rem_val;
    logic        rem_done;
    logic [7:0]  tab_col;
    logic [SCROLL_W+7:0] scroll_ext;

    // Register values clamped to their working range
    assign w_eff   = (width_reg == 7'd0) ? 8'd1 :
                     ({1'b0, width_reg} > 8'(tcce_pkg::MAX_COLUMNS)) ?
                     8'(tcce_pkg::MAX_COLUMNS) : {1'b0, width_reg};
    assign h_eff   = (height_reg == 6'd0) ? 7'd1 :
                     ({1'b0, height_reg} > 7'(tcce_pkg::MAX_ROWS)) ?
                     7'(tcce_pkg::MAX_ROWS) : {1'b0, height_reg};
    assign tab_eff = (tab_reg == 5'd0) ? 5'd1 : tab_reg;

    // New-row step from the current row
    assign col_wrap       = col_reg >= w_eff;
    assign nr_row1        = row_reg + 6'd1;
    assign nr_scroll      = {1'b0, nr_row1} >= h_eff;
    assign nr_row         = nr_scroll ? 6'(h_eff - 7'd1) : nr_row1;
    assign scroll_row_sum = {2'b0, top_reg} + h_eff - 7'd1;

    // Scroll offset advance, kept below the span
    assign scroll_sum = {1'b0, scroll_reg} + SW1'(cellh_reg);
    always_comb begin
        if (scroll_sum >= SW1'(SCROLL_SPAN)) begin
            scroll_adv = SCROLL_W'(scroll_sum - SW1'(SCROLL_SPAN));
        end else begin
            scroll_adv = scroll_sum[SCROLL_W-1:0];
        end
    end

    // Font range check
    assign glyph_end = {2'b0, first_reg} + {1'b0, count_reg};
    assign glyph_out = (char_reg < first_reg) || ({2'b0, char_reg} >= glyph_end);
    assign glyph_sel = glyph_out ? tcce_pkg::CHAR_SPACE : char_reg;

    // Tab stop: column % tab from the serial unit
    assign rem_dividend = col_wrap ? 8'd0 : col_reg;
    assign tab_col      = col_reg + {3'b0, tab_eff} - {3'b0, rem_val};

    tcce_rem u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.rem_start),
        .dividend (rem_dividend),
        .divisor  (tab_eff),
        .rem      (rem_val),
        .done     (rem_done)
    );

    // Per-step state update and result capture
    always_comb begin
        col_next     = col_reg;
        row_next     = row_reg;
        scroll_next  = scroll_reg;
        cnt_next     = cnt_reg;
        rd_next      = rd_reg;
        push         = 1'b0;
        push_kind    = tcce_pkg::KIND_DRAW;
        push_glyph   = glyph_sel;
        push_col     = 7'd0;
        push_row     = 6'd0;
        push_fg      = fg_reg;
        push_bg      = bg_reg;
        draw_col_sum = col_reg + {2'b0, left_reg};
        draw_row_sum = row_reg + {1'b0, top_reg};

        if (cmd.load) begin
            cnt_next = 2'd0;
            rd_next  = 1'b0;
        end

        // scroll result shared by wrap and newline
        if ((cmd.wrap && col_wrap) ||
            (cmd.exec && (char_reg == tcce_pkg::CHAR_LF))) begin
            row_next = nr_row;
            if (nr_scroll) begin
                scroll_next = scroll_adv;
                push        = 1'b1;
                push_kind   = tcce_pkg::KIND_SCROLL;
                push_glyph  = 8'd0;
                push_col    = {1'b0, left_reg};
                push_row    = scroll_row_sum[5:0];
                push_fg     = 16'd0;
                push_bg     = tcce_pkg::CLEAR_COLOR;
            end
        end

        if (cmd.wrap && col_wrap) begin
            col_next = 8'd0;
        end

        if (cmd.tab_apply) begin
            col_next = tab_col;
        end

        if (cmd.exec) begin
            case (char_reg)
                tcce_pkg::CHAR_BS: begin
                    if (col_reg == 8'd0) begin
                        if (row_reg != 6'd0) begin
                            col_next = w_eff - 8'd1;
                            row_next = row_reg - 6'd1;
                        end
                    end else begin
                        col_next = col_reg - 8'd1;
                    end
                    draw_col_sum = col_next + {2'b0, left_reg};
                    draw_row_sum = row_next + {1'b0, top_reg};
                    push       = 1'b1;
                    push_glyph = tcce_pkg::CHAR_SPACE;
                    push_col   = draw_col_sum[6:0];
                    push_row   = draw_row_sum;
                end
                tcce_pkg::CHAR_LF: begin
                    col_next = 8'd0;
                end
                tcce_pkg::CHAR_CR: begin
                    col_next = 8'd0;
                end
                tcce_pkg::CHAR_TAB: begin
                    col_next = col_reg;
                end
                default: begin
                    push     = 1'b1;
                    push_col = draw_col_sum[6:0];
                    push_row = draw_row_sum;
                    col_next = col_reg + 8'd1;
                end
            endcase
        end

        if (push) begin
            cnt_next = cnt_reg + 2'd1;
        end
        if (cmd.pop) begin
            rd_next = ~rd_reg;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= tcce_pkg::RST_WIDTH;
            height_reg <= tcce_pkg::RST_HEIGHT;
            left_reg   <= tcce_pkg::RST_LEFT;
            top_reg    <= tcce_pkg::RST_TOP;
            tab_reg    <= tcce_pkg::RST_TAB;
            cellh_reg  <= tcce_pkg::RST_CELLH;
            first_reg  <= tcce_pkg::RST_FIRST;
            count_reg  <= tcce_pkg::RST_COUNT;
        end else if (cfg_wr_en) begin
            case (tcce_pkg::tcce_reg_t'(cfg_addr))
                tcce_pkg::REG_WIDTH:  width_reg  <= cfg_wr_data[6:0];
                tcce_pkg::REG_HEIGHT: height_reg <= cfg_wr_data[5:0];
                tcce_pkg::REG_LEFT:   left_reg   <= cfg_wr_data[5:0];
                tcce_pkg::REG_TOP:    top_reg    <= cfg_wr_data[4:0];
                tcce_pkg::REG_TAB:    tab_reg    <= cfg_wr_data[4:0];
                tcce_pkg::REG_CELLH:  cellh_reg  <= cfg_wr_data[4:0];
                tcce_pkg::REG_FIRST:  first_reg  <= cfg_wr_data[7:0];
                tcce_pkg::REG_COUNT:  count_reg  <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // Cursor, scroll and slot bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= 8'd0;
            row_reg    <= 6'd0;
            scroll_reg <= '0;
            cnt_reg    <= 2'd0;
            rd_reg     <= 1'b0;
        end else begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            scroll_reg <= scroll_next;
            cnt_reg    <= cnt_next;
            rd_reg     <= rd_next;
        end
    end

    // Item capture, colors resolved on the way in
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            char_reg <= char_code;
            fg_reg   <= tcce_pkg::pick_color(fg_is_rgb, fg_index, fg_rgb);
            bg_reg   <= tcce_pkg::pick_color(bg_is_rgb, bg_index, bg_rgb);
        end
    end

    // Result slots, filled in order
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_kind_reg[cnt_reg[0]]  <= push_kind;
            slot_glyph_reg[cnt_reg[0]] <= push_glyph;
            slot_col_reg[cnt_reg[0]]   <= push_col;
            slot_row_reg[cnt_reg[0]]   <= push_row;
            slot_fg_reg[cnt_reg[0]]    <= push_fg;
            slot_bg_reg[cnt_reg[0]]    <= push_bg;
        end
    end

    // Status
    assign sts.is_nul     = (char_reg == tcce_pkg::CHAR_NUL);
    assign sts.is_tab     = (char_reg == tcce_pkg::CHAR_TAB);
    assign sts.rem_done   = rem_done;
    assign sts.has_result = (cnt_reg != 2'd0);
    assign sts.last       = (cnt_reg == ({1'b0, rd_reg} + 2'd1));

    // Result beat; scroll offset is the value after the whole item
    assign scroll_ext    = {8'd0, scroll_reg};
    assign kind          = slot_kind_reg[rd_reg];
    assign glyph         = slot_glyph_reg[rd_reg];
    assign column        = slot_col_reg[rd_reg];
    assign row           = slot_row_reg[rd_reg];
    assign fg_color      = slot_fg_reg[rd_reg];
    assign bg_color      = slot_bg_reg[rd_reg];
    assign scroll_offset = scroll_ext[7:0];

endmodule

>>> rtl/text_console_cursor_engine.sv
// Text console cursor engine: top level, stream ports and assertions.
// Depends on tcce_pkg, tcce_ctrl, tcce_dp (with tcce_rem) and the assertion header.
//
// Usage:
//   s_* takes one character beat with its foreground and background colors.
//   m_* gives zero, one or two command beats per character: draw a cell
//   (m_tuser low) or scroll and clear (m_tuser high); m_tlast marks the
//   final command of a character. A NUL character produces no beat.
//   cfg_* writes one of the eight window/font registers per cycle; the user
//   must write only while the engine is idle, which the block does not enforce.
// Timing:
//   A character is taken in the idle cycle, wraps the cursor in the next,
//   then executes in the exec state, and its beats are offered in the
//   emit state; the next character is taken after the last beat is accepted.
//   A tab runs the bit-serial remainder unit in place of the exec state.
// Reset: cursor, scroll offset and registers return to their defaults.
// Stall: a low m_tready holds the pending beat; no new character is taken.
`timescale 1ns / 1ps
`include "text_console_cursor_engine_assert.svh"

module text_console_cursor_engine #(
    parameter int SCROLL_SPAN = tcce_pkg::SCROLL_SPAN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [8:0]  cfg_wr_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // char_code[7:0], fg_index[15:8], fg_rgb[39:16], bg_index[47:40], bg_rgb[71:48]
    input  logic [71:0] s_tdata,
    // fg_is_rgb[0], bg_is_rgb[1]
    input  logic [1:0]  s_tuser,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // glyph[7:0], column[14:8], row[20:15], fg_color[36:21], bg_color[52:37],
    // scroll_offset[60:53], zero[63:61]
    output logic [63:0] m_tdata,
    // kind[0]
    output logic        m_tuser,
    output logic        m_tlast
);

    tcce_pkg::tcce_cmd_t cmd;
    tcce_pkg::tcce_sts_t sts;

    logic        kind;
    logic [7:0]  glyph;
    logic [6:0]  column;
    logic [5:0]  row;
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    logic [7:0]  scroll_offset;

    tcce_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    tcce_dp #(
        .SCROLL_SPAN (SCROLL_SPAN)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .char_code     (s_tdata[7:0]),
        .fg_is_rgb     (s_tuser[0]),
        .fg_index      (s_tdata[15:8]),
        .fg_rgb        (s_tdata[39:16]),
        .bg_is_rgb     (s_tuser[1]),
        .bg_index      (s_tdata[47:40]),
        .bg_rgb        (s_tdata[71:48]),
        .cmd           (cmd),
        .sts           (sts),
        .kind          (kind),
        .glyph         (glyph),
        .column        (column),
        .row           (row),
        .fg_color      (fg_color),
        .bg_color      (bg_color),
        .scroll_offset (scroll_offset)
    );

    // Output beat packing
    assign m_tdata = {3'b000, scroll_offset, bg_color, fg_color, row, column, glyph};
    assign m_tuser = kind;
    assign m_tlast = sts.last;

    // One character in flight: never taking input while a beat is offered
    `TCCE_NEVER(a_one_in_flight, s_tready && m_tvalid, "input taken while a result is pending")

    // An accepted character needs at least the wrap cycle before any result
    `TCCE_ASSERT(a_no_early_result, (s_tvalid && s_tready) |=> !m_tvalid, "result too early")

    // After the final beat of a character the engine goes back to idle
    `TCCE_ASSERT(a_last_ends_item, (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid), "no return to idle after last beat")

    // A scroll command always carries the clear color and no glyph
    `TCCE_ASSERT(a_scroll_payload, (m_tvalid && m_tuser) |-> ((m_tdata[52:37] == tcce_pkg::CLEAR_COLOR) && (m_tdata[7:0] == 8'd0)), "bad scroll command payload")

endmodule

>>> test/testbench.sv
// Self-checking testbench for the text console cursor engine.
// Drives character beats and window settings, and predicts every command beat.
// Depends on tcce_pkg and the text_console_cursor_engine RTL only.
`timescale 1ns / 1ps

module testbench;
    import tcce_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned PHASE_CHARS   = 190;
    localparam int unsigned RAND_PHASES   = 9;

    // s_tdata layout, lowest field last
    typedef struct packed {
        logic [23:0] bg_rgb;
        logic [7:0]  bg_index;
        logic [23:0] fg_rgb;
        logic [7:0]  fg_index;
        logic [7:0]  char_code;
    } char_beat_t;

    // m_tdata layout, lowest field last
    typedef struct packed {
        logic [2:0]  pad;
        logic [7:0]  scroll_offset;
        logic [15:0] bg_color;
        logic [15:0] fg_color;
        logic [5:0]  row;
        logic [6:0]  column;
        logic [7:0]  glyph;
    } cmd_body_t;

    typedef struct packed {
        logic      kind;
        logic      last;
        cmd_body_t body;
    } console_cmd_t;

    // Cursor, scroll and window model; queues the commands each character causes
    class cursor_predictor;
        int unsigned width_reg, height_reg, left_reg, top_reg;
        int unsigned tab_reg, cellh_reg, first_reg, count_reg;
        int unsigned cur_col, cur_row, scroll_px;
        int unsigned mismatches, draws_seen, scrolls_seen;
        console_cmd_t expected_cmds[$];
        console_cmd_t batch[$];

        function new();
            width_reg  = RST_WIDTH;
            height_reg = RST_HEIGHT;
            left_reg   = RST_LEFT;
            top_reg    = RST_TOP;
            tab_reg    = RST_TAB;
            cellh_reg  = RST_CELLH;
            first_reg  = RST_FIRST;
            count_reg  = RST_COUNT;
            cur_col    = 0;
            cur_row    = 0;
            scroll_px  = 0;
        endfunction

        function void write_reg(tcce_reg_t idx, int unsigned val);
            case (idx)
                REG_WIDTH:  width_reg  = val & 127;
                REG_HEIGHT: height_reg = val & 63;
                REG_LEFT:   left_reg   = val & 63;
                REG_TOP:    top_reg    = val & 31;
                REG_TAB:    tab_reg    = val & 31;
                REG_CELLH:  cellh_reg  = val & 31;
                REG_FIRST:  first_reg  = val & 255;
                REG_COUNT:  count_reg  = val & 511;
                default: ;
            endcase
        endfunction

        // 6x6x6 cube channel step to 5 bits
        function logic [4:0] cube_step(int unsigned v);
            return (v == 0) ? 5'd0 : 5'((v * 40 + 55) >> 3);
        endfunction

        // RGB15 with red in the low bits, opaque bit on top
        function logic [15:0] xterm_color(logic is_rgb, logic [7:0] idx, logic [23:0] rgb);
            logic [4:0] r, g, b;
            int unsigned k, lv;
            if (is_rgb) begin
                r = rgb[23:19];
                g = rgb[15:11];
                b = rgb[7:3];
            end else if (idx < 16) begin
                case (idx[3:0])
                    4'd0:    {b, g, r} = 15'h0000;
                    4'd1:    {b, g, r} = 15'h000F;
                    4'd2:    {b, g, r} = 15'h01E0;
                    4'd3:    {b, g, r} = 15'h01EF;
                    4'd4:    {b, g, r} = 15'h3C00;
                    4'd5:    {b, g, r} = 15'h3C0F;
                    4'd6:    {b, g, r} = 15'h3DE0;
                    4'd7:    {b, g, r} = 15'h6318;
                    4'd8:    {b, g, r} = 15'h3DEF;
                    4'd9:    {b, g, r} = 15'h001F;
                    4'd10:   {b, g, r} = 15'h03E0;
                    4'd11:   {b, g, r} = 15'h03FF;
                    4'd12:   {b, g, r} = 15'h7C00;
                    4'd13:   {b, g, r} = 15'h7C1F;
                    4'd14:   {b, g, r} = 15'h7FE0;
                    default: {b, g, r} = 15'h7FFF;
                endcase
            end else if (idx < 232) begin
                k = idx - 16;
                r = cube_step(k / 36);
                g = cube_step((k / 6) % 6);
                b = cube_step(k % 6);
            end else begin
                lv = ((idx - 232) * 10 + 8) >> 3;
                r = 5'(lv);
                g = 5'(lv);
                b = 5'(lv);
            end
            return {1'b1, b, g, r};
        endfunction

        // Cursor down one row; past the bottom it scrolls and clears
        function void advance_row();
            console_cmd_t c;
            int unsigned h;
            h = (height_reg == 0) ? 1 : ((height_reg > MAX_ROWS) ? MAX_ROWS : height_reg);
            cur_row = (cur_row + 1) & 63;
            if (cur_row >= h) begin
                cur_row = h - 1;
                scroll_px = (scroll_px + cellh_reg) % SCROLL_SPAN_DEF;
                c = '0;
                c.kind = KIND_SCROLL;
                c.body.column = 7'(left_reg);
                c.body.row = 6'(top_reg + h - 1);
                c.body.bg_color = xterm_color(1'b0, 8'd0, 24'd0);
                batch.push_back(c);
            end
        endfunction

        function void add_draw(logic [7:0] glyph, logic [15:0] fg, logic [15:0] bg);
            console_cmd_t c;
            c = '0;
            c.kind = KIND_DRAW;
            c.body.glyph = glyph;
            c.body.column = 7'(cur_col + left_reg);
            c.body.row = 6'(cur_row + top_reg);
            c.body.fg_color = fg;
            c.body.bg_color = bg;
            batch.push_back(c);
        endfunction

        // One accepted character beat
        function void take_char(char_beat_t d, logic [1:0] sel);
            logic [15:0] fg, bg;
            int unsigned w, step, code;
            if (d.char_code == CHAR_NUL)
                return;
            fg = xterm_color(sel[0], d.fg_index, d.fg_rgb);
            bg = xterm_color(sel[1], d.bg_index, d.bg_rgb);
            w = (width_reg == 0) ? 1 : ((width_reg > MAX_COLUMNS) ? MAX_COLUMNS : width_reg);
            step = (tab_reg == 0) ? 1 : tab_reg;
            batch.delete();
            // deferred wrap from the previous character
            if (cur_col >= w) begin
                cur_col = 0;
                advance_row();
            end
            case (d.char_code)
                CHAR_BS: begin
                    if (cur_col == 0) begin
                        if (cur_row > 0) begin
                            cur_col = w - 1;
                            cur_row = cur_row - 1;
                        end
                    end else begin
                        cur_col = cur_col - 1;
                    end
                    add_draw(CHAR_SPACE, fg, bg);
                end
                CHAR_TAB: cur_col = (cur_col + step - cur_col % step) & 255;
                CHAR_LF: begin
                    advance_row();
                    cur_col = 0;
                end
                CHAR_CR: cur_col = 0;
                default: begin
                    code = d.char_code;
                    if (code < first_reg || code >= first_reg + count_reg)
                        code = CHAR_SPACE;
                    add_draw(8'(code), fg, bg);
                    cur_col = (cur_col + 1) & 255;
                end
            endcase
            // every command of a character carries the final scroll offset
            foreach (batch[i]) begin
                batch[i].body.scroll_offset = 8'(scroll_px);
                batch[i].last = (i == batch.size() - 1);
                expected_cmds.push_back(batch[i]);
            end
        endfunction

        function void field_ok(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        // One accepted command beat against the oldest prediction
        function void check_cmd(cmd_body_t got, logic kind, logic last);
            console_cmd_t want;
            if (expected_cmds.size() == 0) begin
                $error("command beat with no character pending: 0x%0h", got);
                mismatches++;
                return;
            end
            want = expected_cmds.pop_front();
            if (want.kind == KIND_DRAW)
                draws_seen++;
            else
                scrolls_seen++;
            field_ok("kind", want.kind, kind);
            field_ok("glyph", want.body.glyph, got.glyph);
            field_ok("column", want.body.column, got.column);
            field_ok("row", want.body.row, got.row);
            field_ok("fg_color", want.body.fg_color, got.fg_color);
            field_ok("bg_color", want.body.bg_color, got.bg_color);
            field_ok("scroll_offset", want.body.scroll_offset, got.scroll_offset);
            field_ok("pad", want.body.pad, got.pad);
            field_ok("last", want.last, last);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [8:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    cursor_predictor pred;
    int unsigned send_gap_max = 6;
    int unsigned recv_gap_max = 6;
    bit          hold_req = 1'b0;
    int unsigned long_holds = 0;
    int unsigned chars_sent = 0;
    int unsigned nuls_sent = 0;
    int unsigned settings_used = 0;
    int unsigned cycle_count = 0;

    text_console_cursor_engine u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Beat monitor: predict on input beats, compare on output beats
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                pred.take_char(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
                pred.check_cmd(m_tdata, m_tuser, m_tlast);
        end
    end

    // Result receiver: random stalls, one long hold on request
    initial begin
        int unsigned pause;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                pause = LONG_HOLD;
                hold_req = 1'b0;
                long_holds++;
            end else begin
                pause = $urandom_range(0, recv_gap_max);
            end
            if (pause > 0) begin
                m_tready <= 1'b0;
                repeat (pause) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // Run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("simulation failed");
        $finish;
    end

    task automatic cfg_write(input tcce_reg_t idx, input int unsigned val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= 9'(val);
        @(posedge aclk);
        pred.write_reg(idx, val);
    endtask

    // All eight registers, engine idle
    task automatic write_window(input int unsigned w, h, l, t, ts, ch, first, cnt);
        cfg_write(REG_WIDTH, w);
        cfg_write(REG_HEIGHT, h);
        cfg_write(REG_LEFT, l);
        cfg_write(REG_TOP, t);
        cfg_write(REG_TAB, ts);
        cfg_write(REG_CELLH, ch);
        cfg_write(REG_FIRST, first);
        cfg_write(REG_COUNT, cnt);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // One character beat after a random gap
    task automatic send_code(input logic [7:0] code, input logic [1:0] sel,
                             input logic [7:0] fgi, input logic [7:0] bgi,
                             input logic [23:0] fgr, input logic [23:0] bgr);
        char_beat_t d;
        int unsigned gap;
        d.char_code = code;
        d.fg_index  = fgi;
        d.fg_rgb    = fgr;
        d.bg_index  = bgi;
        d.bg_rgb    = bgr;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= sel;
        do @(posedge aclk); while (!s_tready);
        if (code == CHAR_NUL)
            nuls_sent++;
        else
            chars_sent++;
    endtask

    // Mostly text, with control codes and odd bytes mixed in
    function automatic logic [7:0] pick_code();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)  return CHAR_NUL;
        if (roll < 11) return CHAR_LF;
        if (roll < 15) return CHAR_CR;
        if (roll < 22) return CHAR_TAB;
        if (roll < 30) return CHAR_BS;
        if (roll < 50) return 8'($urandom_range(1, 255));
        return 8'($urandom_range(32, 126));
    endfunction

    // Wait out every expected command, then let tabs and the like finish
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pred.expected_cmds.size() != 0 || s_tvalid)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int unsigned phase, start, w, h;
        pred = new();
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= REG_WIDTH;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset window: colors at the palette edges, control codes, backspace wrap
        send_code(CHAR_NUL, 2'b00, 8'd1, 8'd2, 24'd0, 24'd0);
        send_code(CHAR_BS, 2'b00, 8'd0, 8'd255, 24'd0, 24'd0);
        send_code(8'h41, 2'b00, 8'd15, 8'd16, 24'd0, 24'd0);
        send_code(8'hFF, 2'b00, 8'd231, 8'd232, 24'd0, 24'd0);
        send_code(8'h01, 2'b10, 8'd0, 8'd0, 24'h000000, 24'hFFFFFF);
        send_code(CHAR_TAB, 2'b00, 8'd7, 8'd8, 24'd0, 24'd0);
        send_code(CHAR_BS, 2'b01, 8'd9, 8'd10, 24'hFFFFFF, 24'd0);
        send_code(8'h7E, 2'b00, 8'd255, 8'd0, 24'd0, 24'd0);
        send_code(CHAR_CR, 2'b00, 8'd3, 8'd4, 24'd0, 24'd0);
        send_code(CHAR_LF, 2'b00, 8'd5, 8'd6, 24'd0, 24'd0);
        send_code(CHAR_BS, 2'b11, 8'd0, 8'd0, 24'h123456, 24'h89ABCD);
        send_code(8'h21, 2'b00, 8'd100, 8'd200, 24'd0, 24'd0);
        send_code(8'h42, 2'b00, 8'd50, 8'd250, 24'd0, 24'd0);
        drain();

        // Tiny window: font edges, double scroll, tab past the edge
        write_window(2, 2, 5, 3, 3, 31, 8'h30, 16);
        send_code(8'h30, 2'b00, 8'd1, 8'd2, 24'd0, 24'd0);
        send_code(8'h3F, 2'b00, 8'd3, 8'd4, 24'd0, 24'd0);
        send_code(8'h40, 2'b00, 8'd5, 8'd6, 24'd0, 24'd0);
        send_code(8'h2F, 2'b00, 8'd7, 8'd8, 24'd0, 24'd0);
        send_code(CHAR_LF, 2'b00, 8'd9, 8'd10, 24'd0, 24'd0);
        send_code(CHAR_TAB, 2'b00, 8'd11, 8'd12, 24'd0, 24'd0);
        send_code(8'h41, 2'b00, 8'd13, 8'd14, 24'd0, 24'd0);
        send_code(CHAR_BS, 2'b00, 8'd17, 8'd18, 24'd0, 24'd0);
        send_code(CHAR_BS, 2'b00, 8'd19, 8'd20, 24'd0, 24'd0);
        send_code(CHAR_CR, 2'b00, 8'd21, 8'd22, 24'd0, 24'd0);
        send_code(8'h35, 2'b01, 8'd23, 8'd24, 24'hA5A5A5, 24'd0);
        drain();

        // Random text over a series of window settings
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase)
                0: write_window(1, 1, 63, 31, 0, 31, 255, 1);
                1: write_window(127, 63, 0, 0, 16, 1, 0, 511);
                2: write_window(64, 32, 63, 31, 31, 16, 32, 0);
                3: write_window(0, 0, 17, 9, 1, 0, 0, 256);
                default: begin
                    w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                    : $urandom_range(1, 12);
                    h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                    : $urandom_range(1, 6);
                    write_window(w, h, $urandom_range(0, 63), $urandom_range(0, 31),
                                 $urandom_range(0, 31), $urandom_range(0, 31),
                                 $urandom_range(0, 64), $urandom_range(0, 511));
                end
            endcase
            send_gap_max = (phase % 3 == 1) ? 0 : 6;
            recv_gap_max = (phase % 3 == 2) ? 0 : 6;
            // output held off while input keeps coming
            if (phase == 4)
                hold_req = 1'b1;
            start = chars_sent;
            while (chars_sent - start < PHASE_CHARS)
                send_code(pick_code(), 2'($urandom), 8'($urandom), 8'($urandom),
                          24'($urandom), 24'($urandom));
            drain();
        end

        $display("%0d characters and %0d NULs sent over %0d window settings, %0d long stall(s)",
                 chars_sent, nuls_sent, settings_used, long_holds);
        $display("%0d draw and %0d scroll commands compared field by field",
                 pred.draws_seen, pred.scrolls_seen);
        if (pred.mismatches == 0 && pred.expected_cmds.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
